@@ design/hpq_pkg.sv @@
`timescale 1ns / 1ps

package hpq_pkg;

   localparam int DATA_W  = 32;
   localparam int POS_W   = 8;
   localparam int COUNT_W = 8;

   // operation codes on req_cmd
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_NO_POS = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_DEL_RD,
      S_UP_ISSUE,
      S_UP_CMP,
      S_DOWN_ISSUE,
      S_DOWN_PICK,
      S_DOWN_CMP,
      S_PLACE,
      S_FINISH,
      S_REPORT
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  removed_value;
      status_type                status;
      logic        [COUNT_W-1:0] count;
      logic signed [DATA_W-1:0]  top_value;
      logic signed [DATA_W-1:0]  last_value;
      logic                      is_empty;
   } result_type;

endpackage

@@ design/binary_max_heap_queue.sv @@
`timescale 1ns / 1ps
// sequence: a refused item goes straight to the report; an insert climbs level by level;
//   a delete of the last entry skips the sift, any other delete climbs or sinks level by
//   level; rsp_stall can hold the sequencer in its report state while a result waits
// throughput: one item at a time; the heap depth, log2(CAPACITY), sets the sift loop length
//   through the single shared comparator and the one-write, two-read heap store
// reset: synchronous, active high; empties the heap and drops any pending result,
//   store contents are left as they are and values from unfilled positions are never used
module binary_max_heap_queue import hpq_pkg::*; #(
   parameter int CAPACITY = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic        [POS_W-1:0]   req_position,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DATA_W-1:0]  rsp_removed_value,
   output logic        [1:0]         rsp_status,
   output logic        [COUNT_W-1:0] rsp_count,
   output logic signed [DATA_W-1:0]  rsp_top_value,
   output logic signed [DATA_W-1:0]  rsp_last_value,
   output logic                      rsp_is_empty
);

   localparam int AW = $clog2(CAPACITY);

   // sequencer handshake
   logic       idle;
   logic       start;
   logic       out_free;
   logic       res_valid;
   result_type result;

   // heap store port
   logic                     wr_en;
   logic        [AW-1:0]     wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic        [AW-1:0]     rd_a_addr;
   logic        [AW-1:0]     rd_b_addr;
   logic signed [DATA_W-1:0] rd_a_data;
   logic signed [DATA_W-1:0] rd_b_data;

   // response register, separate from the sequencer so a new item can be taken
   // while the previous result still waits downstream
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   // new item only when the sequencer sits idle
   assign req_stall = !idle;
   assign start     = req_valid && !req_stall;

   // the sequencer may hand over a result when the register is empty or draining
   assign out_free = !rsp_valid_ff || !rsp_stall;

   hpq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (req_cmd),
      .value     (req_value),
      .position  (req_position),
      .out_free  (out_free),
      .idle      (idle),
      .res_valid (res_valid),
      .result    (result),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // heap positions 1..CAPACITY live at addresses 0..CAPACITY-1
   hpq_store #(
      .DEPTH (CAPACITY)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         // load a fresh result item
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         // item taken downstream
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_ff.removed_value;
   assign rsp_status        = rsp_ff.status;
   assign rsp_count         = rsp_ff.count;
   assign rsp_top_value     = rsp_ff.top_value;
   assign rsp_last_value    = rsp_ff.last_value;
   assign rsp_is_empty      = rsp_ff.is_empty;

endmodule

@@ design/hpq_store.sv @@
`timescale 1ns / 1ps

module hpq_store import hpq_pkg::*; #(
   parameter int  DEPTH = 128,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic        [AW-1:0]     wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic        [AW-1:0]     rd_a_addr,
   input  logic        [AW-1:0]     rd_b_addr,
   output logic signed [DATA_W-1:0] rd_a_data,
   output logic signed [DATA_W-1:0] rd_b_data
);

   logic signed [DATA_W-1:0] mem_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_a_ff;
   logic signed [DATA_W-1:0] rd_b_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

@@ design/hpq_ctrl.sv @@
`timescale 1ns / 1ps

module hpq_ctrl import hpq_pkg::*; #(
   parameter int  CAPACITY = 128,
   localparam int AW       = $clog2(CAPACITY),
   localparam int PW       = $clog2(CAPACITY + 1),
   localparam int CW       = (PW > POS_W) ? PW : POS_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     cmd,
   input  logic signed [DATA_W-1:0] value,
   input  logic        [POS_W-1:0]  position,
   input  logic                     out_free,
   output logic                     idle,
   output logic                     res_valid,
   output result_type               result,
   output logic                     wr_en,
   output logic        [AW-1:0]     wr_addr,
   output logic signed [DATA_W-1:0] wr_data,
   output logic        [AW-1:0]     rd_a_addr,
   output logic        [AW-1:0]     rd_b_addr,
   input  logic signed [DATA_W-1:0] rd_a_data,
   input  logic signed [DATA_W-1:0] rd_b_data
);

   localparam logic [PW-1:0] ONE_P = PW'(1);
   localparam logic [PW:0]   ONE_L = (PW + 1)'(1);
   localparam logic [PW-1:0] FULL  = PW'(CAPACITY);

   state_type                state_ff, state_in;
   logic                     cmd_ff, cmd_in;
   logic        [POS_W-1:0]  pos_ff, pos_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W-1:0] removed_ff, removed_in;
   status_type               status_ff, status_in;
   logic        [PW-1:0]     cnt_ff, cnt_in;
   logic        [PW-1:0]     k_ff, k_in;
   logic                     up_only_ff, up_only_in;
   logic signed [DATA_W-1:0] pick_val_ff, pick_val_in;
   logic                     pick_right_ff, pick_right_in;

   // shared signed comparator
   logic signed [DATA_W-1:0] cmp_a, cmp_b;
   logic                     cmp_gt;

   logic [CW-1:0] pos_ext, cnt_ext;
   logic          pos_bad;
   logic [PW-1:0] parent;
   logic [PW:0]   l_pos, r_pos, cnt_w;
   logic          has_left, has_right;
   logic [AW-1:0] k_addr, parent_addr, cnt_addr, pos_addr, left_addr, right_addr;

   assign cmp_gt = cmp_a > cmp_b;

   assign pos_ext     = CW'(pos_ff);
   assign cnt_ext     = CW'(cnt_ff);
   assign pos_bad     = (pos_ff == '0) || (pos_ext > cnt_ext);
   assign parent      = k_ff >> 1;
   assign l_pos       = {k_ff, 1'b0};
   assign r_pos       = l_pos + ONE_L;
   assign cnt_w       = {1'b0, cnt_ff};
   assign has_left    = l_pos <= cnt_w;
   assign has_right   = r_pos <= cnt_w;
   assign k_addr      = AW'(k_ff - ONE_P);
   assign parent_addr = AW'(parent - ONE_P);
   assign cnt_addr    = AW'(cnt_ff - ONE_P);
   assign pos_addr    = AW'(pos_ext - CW'(1));
   assign left_addr   = AW'(l_pos - ONE_L);
   assign right_addr  = has_right ? AW'(l_pos) : left_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      removed_ff    <= removed_in;
      status_ff     <= status_in;
      k_ff          <= k_in;
      up_only_ff    <= up_only_in;
      pick_val_ff   <= pick_val_in;
      pick_right_ff <= pick_right_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      removed_in    = removed_ff;
      status_in     = status_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      up_only_in    = up_only_ff;
      pick_val_in   = pick_val_ff;
      pick_right_in = pick_right_ff;
      cmp_a         = val_ff;
      cmp_b         = rd_a_data;
      wr_en         = 1'b0;
      wr_addr       = k_addr;
      wr_data       = val_ff;
      rd_a_addr     = '0;
      rd_b_addr     = '0;
      idle          = 1'b0;
      res_valid     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            if (start) begin
               cmd_in     = cmd;
               val_in     = value;
               pos_in     = position;
               removed_in = '0;
               status_in  = STATUS_DONE;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (cmd_ff == CMD_INSERT) begin
               if (cnt_ff == FULL) begin
                  status_in = STATUS_FULL;
                  state_in  = S_FINISH;
               end else begin
                  cnt_in     = cnt_ff + ONE_P;
                  k_in       = cnt_ff + ONE_P;
                  up_only_in = 1'b1;
                  state_in   = S_UP_ISSUE;
               end
            end else if (pos_bad) begin
               status_in = STATUS_NO_POS;
               state_in  = S_FINISH;
            end else begin
               rd_a_addr = pos_addr;
               rd_b_addr = cnt_addr;
               state_in  = S_DEL_RD;
            end
         end
         S_DEL_RD: begin
            // removed entry and last entry arrive together
            removed_in = rd_a_data;
            val_in     = rd_b_data;
            cnt_in     = cnt_ff - ONE_P;
            k_in       = PW'(pos_ext);
            up_only_in = 1'b0;
            state_in   = (pos_ext == cnt_ext) ? S_FINISH : S_UP_ISSUE;
         end
         S_UP_ISSUE: begin
            if (k_ff == ONE_P) begin
               state_in = up_only_ff ? S_PLACE : S_DOWN_ISSUE;
            end else begin
               rd_a_addr = parent_addr;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            cmp_a = val_ff;
            cmp_b = rd_a_data;
            if (cmp_gt) begin
               // parent moves down into the hole
               wr_en      = 1'b1;
               wr_data    = rd_a_data;
               k_in       = parent;
               up_only_in = 1'b1;
               state_in   = S_UP_ISSUE;
            end else begin
               state_in = up_only_ff ? S_PLACE : S_DOWN_ISSUE;
            end
         end
         S_DOWN_ISSUE: begin
            if (!has_left) begin
               state_in = S_PLACE;
            end else begin
               rd_a_addr = left_addr;
               rd_b_addr = right_addr;
               state_in  = S_DOWN_PICK;
            end
         end
         S_DOWN_PICK: begin
            // equal children go right
            cmp_a         = rd_a_data;
            cmp_b         = rd_b_data;
            pick_right_in = has_right && !cmp_gt;
            pick_val_in   = (has_right && !cmp_gt) ? rd_b_data : rd_a_data;
            state_in      = S_DOWN_CMP;
         end
         S_DOWN_CMP: begin
            cmp_a = pick_val_ff;
            cmp_b = val_ff;
            if (cmp_gt) begin
               wr_en    = 1'b1;
               wr_data  = pick_val_ff;
               k_in     = pick_right_ff ? PW'(r_pos) : PW'(l_pos);
               state_in = S_DOWN_ISSUE;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            rd_a_addr = '0;
            rd_b_addr = (cnt_ff == '0) ? '0 : cnt_addr;
            state_in  = S_REPORT;
         end
         S_REPORT: begin
            // keep reading top and last so they hold while the result waits
            rd_a_addr = '0;
            rd_b_addr = (cnt_ff == '0) ? '0 : cnt_addr;
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      result.removed_value = removed_ff;
      result.status        = status_ff;
      result.count         = cnt_ext[COUNT_W-1:0];
      result.top_value     = (cnt_ff != '0) ? rd_a_data : '0;
      result.last_value    = (cnt_ff != '0) ? rd_b_data : '0;
      result.is_empty      = (cnt_ff == '0);
   end

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !wr_en)
      else $error("store written while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL)
      else $error("entry count beyond capacity");

   a_report_idle: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> state_ff == S_IDLE)
      else $error("sequencer not idle after result");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      res_valid && status_ff == STATUS_FULL |-> cnt_ff == FULL)
      else $error("full status without full heap");

   a_start_check: assert property (@(posedge clock) disable iff (reset)
      start |=> state_ff == S_CHECK && $stable(cnt_ff))
      else $error("accepted item not decoded");

endmodule
